// ----- sv/touch_gesture_classifier_macros.svh -----
// Assertion macros for the gesture classifier checker.
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// Implication checked on every clock edge while out of reset.
`define TGC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked while out of reset.
`define TGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tgc_pkg.sv -----
package tgc_pkg;

    localparam int unsigned LIFT_FRAMES        = 3;
    localparam int unsigned MOVE_INTERVAL_MS   = 100;
    localparam int unsigned TURN_MIN_GAP_MS    = 120;
    localparam int unsigned ZONE_TOP_Y         = 150;
    localparam int unsigned RELEASE_HOLDOFF_MS = 80;
    localparam int unsigned QUEUE_DEPTH        = 2;
    localparam int unsigned QUEUE_AW           = 1;

    localparam logic [1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [1:0] MODE_SUP_FOR = 2'd1;
    localparam logic [1:0] MODE_SUP_REL = 2'd2;

    localparam logic [3:0] EV_DOWN      = 4'd0;
    localparam logic [3:0] EV_MOVE      = 4'd1;
    localparam logic [3:0] EV_UP        = 4'd2;
    localparam logic [3:0] EV_TAP       = 4'd3;
    localparam logic [3:0] EV_LONG      = 4'd4;
    localparam logic [3:0] EV_SW_LEFT   = 4'd5;
    localparam logic [3:0] EV_SW_RIGHT  = 4'd6;
    localparam logic [3:0] EV_SW_UP     = 4'd7;
    localparam logic [3:0] EV_SW_DOWN   = 4'd8;
    localparam logic [3:0] EV_PAGE_NEXT = 4'd9;
    localparam logic [3:0] EV_PAGE_PREV = 4'd10;

    localparam logic [2:0] REG_SCREEN_W   = 3'd0;
    localparam logic [2:0] REG_SCREEN_H   = 3'd1;
    localparam logic [2:0] REG_TAP_SLOP   = 3'd2;
    localparam logic [2:0] REG_LONG_PRESS = 3'd3;
    localparam logic [2:0] REG_SWIPE      = 3'd4;
    localparam logic [2:0] REG_PRESS_DB   = 3'd5;
    localparam logic [2:0] REG_QT_STABLE  = 3'd6;
    localparam logic [2:0] REG_QT_CANCEL  = 3'd7;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        now_ms;
        logic               touch_enabled;
        logic               touch_pressed;
        logic [2:0]         touch_count;
        logic signed [11:0] raw_x;
        logic signed [11:0] raw_y;
        logic               display_pushing;
        logic               reader_menu_active;
        logic               body_visible;
        logic               turn_accepted;
        logic [15:0]        cooldown_ms;
    } tgc_in_t;

    typedef struct packed {
        logic [3:0]         event_kind;
        logic [10:0]        point_x;
        logic [10:0]        point_y;
        logic signed [11:0] raw_point_x;
        logic signed [11:0] raw_point_y;
        logic signed [3:0]  event_value;
        logic [31:0]        event_time;
        logic               last_of_run;
    } tgc_out_t;

    typedef struct packed {
        logic [10:0] screen_width;
        logic [10:0] screen_height;
        logic [9:0]  tap_slop_px;
        logic [15:0] long_press_ms;
        logic [9:0]  swipe_px;
        logic [15:0] press_debounce_ms;
        logic [15:0] quick_turn_stable_ms;
        logic [9:0]  quick_turn_cancel_px;
    } tgc_cfg_t;

    // one decoded step: up to two results, sent in order
    typedef struct packed {
        logic     two;
        tgc_out_t ev0;
        tgc_out_t ev1;
    } tgc_job_t;

endpackage

// ----- sv/tgc_cfg_regs.sv -----
module tgc_cfg_regs
    import tgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output tgc_cfg_t    cfg
);

    tgc_cfg_t   cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width         <= 11'd540;
            cfg_reg.screen_height        <= 11'd960;
            cfg_reg.tap_slop_px          <= 10'd50;
            cfg_reg.long_press_ms        <= 16'd600;
            cfg_reg.swipe_px             <= 10'd80;
            cfg_reg.press_debounce_ms    <= 16'd18;
            cfg_reg.quick_turn_stable_ms <= 16'd35;
            cfg_reg.quick_turn_cancel_px <= 10'd58;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_SCREEN_W:   cfg_reg.screen_width         <= pwdata[10:0];
                REG_SCREEN_H:   cfg_reg.screen_height        <= pwdata[10:0];
                REG_TAP_SLOP:   cfg_reg.tap_slop_px          <= pwdata[9:0];
                REG_LONG_PRESS: cfg_reg.long_press_ms        <= pwdata[15:0];
                REG_SWIPE:      cfg_reg.swipe_px             <= pwdata[9:0];
                REG_PRESS_DB:   cfg_reg.press_debounce_ms    <= pwdata[15:0];
                REG_QT_STABLE:  cfg_reg.quick_turn_stable_ms <= pwdata[15:0];
                REG_QT_CANCEL:  cfg_reg.quick_turn_cancel_px <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_SCREEN_W:   prdata[10:0] = cfg_reg.screen_width;
            REG_SCREEN_H:   prdata[10:0] = cfg_reg.screen_height;
            REG_TAP_SLOP:   prdata[9:0]  = cfg_reg.tap_slop_px;
            REG_LONG_PRESS: prdata[15:0] = cfg_reg.long_press_ms;
            REG_SWIPE:      prdata[9:0]  = cfg_reg.swipe_px;
            REG_PRESS_DB:   prdata[15:0] = cfg_reg.press_debounce_ms;
            REG_QT_STABLE:  prdata[15:0] = cfg_reg.quick_turn_stable_ms;
            REG_QT_CANCEL:  prdata[9:0]  = cfg_reg.quick_turn_cancel_px;
            default:        prdata = '0;
        endcase
    end

endmodule

// ----- sv/tgc_front.sv -----
module tgc_front
    import tgc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tgc_cfg_t cfg,
    input  logic     in_valid,
    input  tgc_in_t  in_item,
    output logic     in_stall,
    output logic     job_valid,
    output tgc_job_t job,
    input  logic     job_full
);

    logic        finger_down_reg, finger_down_next;
    logic        wait_rel_reg, wait_rel_next;
    logic [31:0] sup_until_reg, sup_until_next;
    logic [31:0] last_rel_reg, last_rel_next;
    logic [31:0] press_time_reg, press_time_next;
    logic [31:0] last_move_reg, last_move_next;
    logic [31:0] last_turn_reg, last_turn_next;
    logic [1:0]  miss_reg, miss_next;
    logic [21:0] press_xy_reg, press_xy_next;
    logic [23:0] press_raw_reg, press_raw_next;
    logic [21:0] latest_xy_reg, latest_xy_next;
    logic [23:0] latest_raw_reg, latest_raw_next;
    logic [2:0]  tflags_reg, tflags_next;
    logic [47:0] dturn_reg, dturn_next;

    logic        take;
    logic        pressed, pushing, reading;
    logic [10:0] w_eff, h_eff, cx, cy, third, two_third;
    logic [12:0] w2;
    logic [23:0] third_prod, two_third_prod;
    logic [21:0] cur;
    logic [23:0] raw;
    logic        zone_ok, zone_next;
    logic        turn_gap_ok;
    logic signed [11:0] qdx, qdy, rdx, rdy;
    logic [10:0] qadx, qady, qm, radx, rady, rm;
    logic [31:0] held;

    assign in_stall = job_full;
    assign take     = in_valid && !job_full;
    assign pushing  = in_item.display_pushing;
    assign pressed  = in_item.touch_pressed && (in_item.touch_count == 3'd1);
    assign reading  = in_item.reader_menu_active && in_item.body_visible;

    assign w_eff = (cfg.screen_width == 11'd0) ? 11'd1 : cfg.screen_width;
    assign h_eff = (cfg.screen_height == 11'd0) ? 11'd1 : cfg.screen_height;
    assign cx = in_item.raw_x[11] ? 11'd0 :
                ({1'b0, in_item.raw_x[10:0]} >= {1'b0, w_eff}) ? w_eff - 11'd1 :
                in_item.raw_x[10:0];
    assign cy = in_item.raw_y[11] ? 11'd0 :
                ({1'b0, in_item.raw_y[10:0]} >= {1'b0, h_eff}) ? h_eff - 11'd1 :
                in_item.raw_y[10:0];
    assign cur = {cy, cx};
    assign raw = {in_item.raw_y, in_item.raw_x};

    // divide by 3 as (n * 2731) >> 13, exact for n below 6144 in the 24-bit product
    assign w2             = {1'b0, cfg.screen_width, 1'b0};
    assign third_prod     = 24'(cfg.screen_width) * 24'd2731;
    assign two_third_prod = 24'(w2) * 24'd2731;
    assign third          = third_prod[23:13];
    assign two_third      = two_third_prod[23:13];
    assign zone_ok   = reading && (cy >= 11'(ZONE_TOP_Y)) &&
                       ((cx < third) || (cx > two_third));
    assign zone_next = !(cx < third);

    assign turn_gap_ok = (in_item.now_ms - last_turn_reg) >= 32'(TURN_MIN_GAP_MS);

    assign qdx  = $signed({1'b0, cx}) - $signed({1'b0, press_xy_reg[10:0]});
    assign qdy  = $signed({1'b0, cy}) - $signed({1'b0, press_xy_reg[21:11]});
    assign qadx = qdx[11] ? 11'(-qdx) : qdx[10:0];
    assign qady = qdy[11] ? 11'(-qdy) : qdy[10:0];
    assign qm   = (qadx > qady) ? qadx : qady;

    assign rdx  = $signed({1'b0, latest_xy_reg[10:0]}) - $signed({1'b0, press_xy_reg[10:0]});
    assign rdy  = $signed({1'b0, latest_xy_reg[21:11]}) - $signed({1'b0, press_xy_reg[21:11]});
    assign radx = rdx[11] ? 11'(-rdx) : rdx[10:0];
    assign rady = rdy[11] ? 11'(-rdy) : rdy[10:0];
    assign rm   = (radx > rady) ? radx : rady;
    assign held = in_item.now_ms - press_time_reg;

    function automatic tgc_out_t mk(input logic [3:0] k, input logic [21:0] xy,
                                    input logic [23:0] r, input logic [3:0] v,
                                    input logic [31:0] t, input logic last);
        tgc_out_t o;
        o.event_kind  = k;
        o.point_x     = xy[10:0];
        o.point_y     = xy[21:11];
        o.raw_point_x = r[11:0];
        o.raw_point_y = r[23:12];
        o.event_value = v;
        o.event_time  = t;
        o.last_of_run = last;
        return o;
    endfunction

    always_comb
    begin
        logic       done;
        logic       ok;
        logic [3:0] cnt;
        finger_down_next = finger_down_reg;
        wait_rel_next    = wait_rel_reg;
        sup_until_next   = sup_until_reg;
        last_rel_next    = last_rel_reg;
        press_time_next  = press_time_reg;
        last_move_next   = last_move_reg;
        last_turn_next   = last_turn_reg;
        miss_next        = miss_reg;
        press_xy_next    = press_xy_reg;
        press_raw_next   = press_raw_reg;
        latest_xy_next   = latest_xy_reg;
        latest_raw_next  = latest_raw_reg;
        tflags_next      = tflags_reg;
        dturn_next       = dturn_reg;
        job_valid        = 1'b0;
        job              = '0;
        done             = 1'b0;
        ok               = 1'b0;
        cnt              = {1'b0, in_item.touch_count};

        if (in_item.mode == MODE_SUP_FOR || in_item.mode == MODE_SUP_REL)
        begin
            sup_until_next   = in_item.now_ms + 32'(in_item.cooldown_ms);
            wait_rel_next    = (in_item.mode == MODE_SUP_REL);
            finger_down_next = 1'b0;
            last_move_next   = '0;
            miss_next        = '0;
            tflags_next      = '0;
            dturn_next       = '0;
        end
        else if (in_item.mode == MODE_SAMPLE)
        begin
            if (!in_item.touch_enabled)
            begin
                if (finger_down_reg)
                begin
                    finger_down_next = 1'b0;
                    wait_rel_next    = 1'b0;
                end
                miss_next   = '0;
                tflags_next = '0;
                dturn_next  = '0;
                done        = 1'b1;
            end

            if (!done && !pushing && dturn_reg[0])
            begin
                dturn_next = '0;
                if (turn_gap_ok && reading && in_item.turn_accepted)
                begin
                    job_valid        = 1'b1;
                    job.ev0          = mk(dturn_reg[1] ? EV_PAGE_NEXT : EV_PAGE_PREV,
                                          dturn_reg[23:2], dturn_reg[47:24],
                                          dturn_reg[1] ? 4'sd1 : -4'sd1,
                                          in_item.now_ms, 1'b1);
                    last_turn_next   = in_item.now_ms;
                    finger_down_next = 1'b0;
                    tflags_next      = '0;
                    if (pressed)
                    begin
                        wait_rel_next  = 1'b1;
                        sup_until_next = in_item.now_ms + 32'(RELEASE_HOLDOFF_MS);
                    end
                    done = 1'b1;
                end
            end

            if (!done && pressed)
            begin
                miss_next = '0;
                if (pushing || wait_rel_reg || (in_item.now_ms < sup_until_reg))
                begin
                    latest_xy_next  = cur;
                    latest_raw_next = raw;
                    if (pushing && !dturn_reg[0] && zone_ok)
                        dturn_next = {raw, cur, zone_next, 1'b1};
                    if (pushing)
                        finger_down_next = 1'b0;
                end
                else if (!finger_down_reg)
                begin
                    if ((in_item.now_ms - last_rel_reg) >= 32'(cfg.press_debounce_ms))
                    begin
                        finger_down_next = 1'b1;
                        press_time_next  = in_item.now_ms;
                        press_xy_next    = cur;
                        latest_xy_next   = cur;
                        press_raw_next   = raw;
                        latest_raw_next  = raw;
                        last_move_next   = in_item.now_ms;
                        if (zone_ok)
                            tflags_next = {2'b0, 1'b1} | {1'b0, zone_next, 1'b0};
                        else
                            tflags_next = tflags_reg & 3'b010;
                        job_valid = 1'b1;
                        job.ev0   = mk(EV_DOWN, cur, raw, cnt, in_item.now_ms, 1'b1);
                    end
                end
                else
                begin
                    latest_xy_next  = cur;
                    latest_raw_next = raw;
                    if (tflags_reg[0] && !tflags_reg[2])
                    begin
                        if (qm > {1'b0, cfg.quick_turn_cancel_px})
                            tflags_next = '0;
                        else if (held >= 32'(cfg.quick_turn_stable_ms) && turn_gap_ok &&
                                 reading && in_item.turn_accepted)
                        begin
                            ok = 1'b1;
                            job_valid        = 1'b1;
                            job.ev0          = mk(tflags_reg[1] ? EV_PAGE_NEXT : EV_PAGE_PREV,
                                                  press_xy_reg, press_raw_reg,
                                                  tflags_reg[1] ? 4'sd1 : -4'sd1,
                                                  in_item.now_ms, 1'b1);
                            last_turn_next   = in_item.now_ms;
                            tflags_next      = tflags_reg | 3'b100;
                            finger_down_next = 1'b0;
                            wait_rel_next    = 1'b1;
                            sup_until_next   = in_item.now_ms + 32'(RELEASE_HOLDOFF_MS);
                        end
                    end
                    if (!ok && (in_item.now_ms - last_move_reg) >= 32'(MOVE_INTERVAL_MS))
                    begin
                        last_move_next = in_item.now_ms;
                        job_valid      = 1'b1;
                        job.ev0        = mk(EV_MOVE, cur, raw, cnt, in_item.now_ms, 1'b1);
                    end
                end
            end
            else if (!done)
            begin
                if (finger_down_reg && ({30'd0, miss_reg} < 32'(LIFT_FRAMES)))
                    miss_next = miss_reg + 2'd1;
                else
                begin
                    if (!finger_down_reg)
                        miss_next = '0;
                    if (wait_rel_reg && (in_item.now_ms >= sup_until_reg))
                        wait_rel_next = 1'b0;
                    if (!pushing && finger_down_reg)
                    begin
                        finger_down_next = 1'b0;
                        miss_next        = '0;
                        tflags_next      = '0;
                        last_rel_next    = in_item.now_ms;
                        job_valid        = 1'b1;
                        job.ev0          = mk(EV_UP, latest_xy_reg, latest_raw_reg, cnt,
                                              in_item.now_ms, 1'b0);
                        job.two          = 1'b1;
                        if (rm <= {1'b0, cfg.tap_slop_px})
                            job.ev1 = mk(held >= 32'(cfg.long_press_ms) ? EV_LONG : EV_TAP,
                                         press_xy_reg, latest_raw_reg, cnt,
                                         in_item.now_ms, 1'b1);
                        else if (radx > rady && radx >= {1'b0, cfg.swipe_px})
                            job.ev1 = mk(rdx[11] ? EV_SW_LEFT : EV_SW_RIGHT,
                                         latest_xy_reg, latest_raw_reg, cnt,
                                         in_item.now_ms, 1'b1);
                        else if (rady >= {1'b0, cfg.swipe_px})
                            job.ev1 = mk((rdy[11] || rdy == 12'sd0) ? EV_SW_UP
                                                                    : EV_SW_DOWN,
                                         latest_xy_reg, latest_raw_reg, cnt,
                                         in_item.now_ms, 1'b1);
                        else
                        begin
                            job.two = 1'b0;
                            job.ev0.last_of_run = 1'b1;
                        end
                    end
                end
            end
        end
        if (!take)
            job_valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finger_down_reg <= 1'b0;
            wait_rel_reg    <= 1'b0;
            sup_until_reg   <= '0;
            last_rel_reg    <= '0;
            press_time_reg  <= '0;
            last_move_reg   <= '0;
            last_turn_reg   <= '0;
            miss_reg        <= '0;
            press_xy_reg    <= '0;
            press_raw_reg   <= '0;
            latest_xy_reg   <= '0;
            latest_raw_reg  <= '0;
            tflags_reg      <= '0;
            dturn_reg       <= '0;
        end
        else if (take)
        begin
            finger_down_reg <= finger_down_next;
            wait_rel_reg    <= wait_rel_next;
            sup_until_reg   <= sup_until_next;
            last_rel_reg    <= last_rel_next;
            press_time_reg  <= press_time_next;
            last_move_reg   <= last_move_next;
            last_turn_reg   <= last_turn_next;
            miss_reg        <= miss_next;
            press_xy_reg    <= press_xy_next;
            press_raw_reg   <= press_raw_next;
            latest_xy_reg   <= latest_xy_next;
            latest_raw_reg  <= latest_raw_next;
            tflags_reg      <= tflags_next;
            dturn_reg       <= dturn_next;
        end
    end

endmodule

// ----- sv/tgc_back.sv -----
module tgc_back
    import tgc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    input  tgc_job_t job,
    output logic     job_full,
    output logic     out_valid,
    output tgc_out_t out_item,
    input  logic     out_stall
);

    tgc_job_t            q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wp_reg, rp_reg;
    logic [QUEUE_AW:0]   cnt_reg;
    logic                sub_reg;
    logic                pop, adv, push;
    tgc_job_t            head;

    assign head      = q_mem[rp_reg];
    assign out_valid = (cnt_reg != '0);
    assign out_item  = sub_reg ? head.ev1 : head.ev0;
    assign job_full  = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push      = job_valid;
    assign adv       = out_valid && !out_stall;
    assign pop       = adv && (sub_reg || !head.two);

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wp_reg] <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
            sub_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (adv)
                sub_reg <= !pop;
            cnt_reg <= cnt_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
        end
    end

endmodule

// ----- sv/touch_gesture_classifier.sv -----
// Single-touch gesture classifier.
// in channel: one transfer per touch sample or suppress command (in_valid, in_stall, in_item).
// out channel: event transfers (out_valid, out_stall, out_item); last_of_run marks the
//   final event caused by one input.
// Config: APB registers at 4*i; the user must write them only while idle, which the
// block does not enforce; reads return values. A front stage classifies each input and
// writes up to two events into a two-entry queue; the back stage drains one event per cycle
// while out_stall is low. Events are registered in the queue before they reach out_item.
// Throughput: one input per cycle while in_stall is low; a release producing two events
// is sent as separate transfers; the output bounds sustained rate at one event per cycle.
// Reset clears all gesture state and the queue; registers return to defaults.
// When the receiver stalls, events wait in the queue; in_stall rises when it is full.
module touch_gesture_classifier
    import tgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  tgc_in_t     in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output tgc_out_t    out_item
);

    tgc_cfg_t cfg;
    logic     job_valid, job_full;
    tgc_job_t job;

    tgc_cfg_regs u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
    );

    tgc_front u_front (
        .clk, .rst_n, .cfg, .in_valid, .in_item, .in_stall,
        .job_valid, .job, .job_full
    );

    tgc_back u_back (
        .clk, .rst_n, .job_valid, .job, .job_full,
        .out_valid, .out_item, .out_stall
    );

endmodule

// ----- sv/tgc_checker.sv -----
`include "touch_gesture_classifier_macros.svh"
module tgc_checker
    import tgc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input tgc_out_t out_item
);

    `TGC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled event changed")
    `TGC_ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, out_item.event_kind <= EV_PAGE_PREV, "bad event kind")
    `TGC_ASSERT_IMPL(a_pair_end, clk, rst_n, out_valid && !out_stall && (out_item.event_kind != EV_UP), out_item.last_of_run, "non-up event not last")
    `TGC_ASSERT_NEXT(a_stall_src, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")

endmodule

bind touch_gesture_classifier tgc_checker u_chk (
    .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_item
);

// ----- tb/sv/touch_gesture_classifier_test.sv -----
`timescale 1ns / 1ps

module touch_gesture_classifier_test;
    import tgc_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        in_stall;
    tgc_in_t     in_item = '0;
    logic        out_valid;
    logic        out_stall = 0;
    tgc_out_t    out_item;

    touch_gesture_classifier dut (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    typedef struct {
        tgc_in_t    item;
        bit         known;
        int         n;
        logic [3:0] kind;
    } row_t;

    row_t      stim_rows[$];
    tgc_out_t  pending_events[$];
    tgc_out_t  step_events[$];
    tgc_cfg_t  cfg;
    int        errors = 0;
    int        sent = 0;
    int        checked = 0;
    bit        calm = 0;
    logic [31:0] ms_now;

    // gesture state
    bit          finger, wfr;
    logic [31:0] sup_until, rel_t, press_t, move_t, turn_t;
    int          miss;
    int          press_x, press_y, late_x, late_y;
    logic [11:0] press_rx, press_ry, late_rx, late_ry;
    bit          cand, nxt, fired;
    bit          def_valid, def_next;
    int          def_x, def_y;
    logic [11:0] def_rx, def_ry;

    task automatic report(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic int clampc(int v, int lim);
        if (lim == 0) lim = 1;
        if (v < 0) v = 0;
        if (v >= lim) v = lim - 1;
        return v;
    endfunction

    function automatic int zone_of(tgc_in_t it, int x, int y);
        int w;
        w = cfg.screen_width;
        if (!it.reader_menu_active || !it.body_visible) return -1;
        if (y < ZONE_TOP_Y) return -1;
        if (x < w / 3) return 0;
        if (x > (w * 2) / 3) return 1;
        return -1;
    endfunction

    function automatic void add_ev(logic [3:0] kind, int x, int y, logic [11:0] rx,
                                   logic [11:0] ry, logic signed [3:0] val, logic [31:0] t);
        tgc_out_t e;
        e.event_kind = kind;
        e.point_x = 11'(x);
        e.point_y = 11'(y);
        e.raw_point_x = rx;
        e.raw_point_y = ry;
        e.event_value = val;
        e.event_time = t;
        e.last_of_run = 0;
        step_events.push_back(e);
    endfunction

    function automatic bit post_turn(tgc_in_t it, bit next, int x, int y,
                                     logic [11:0] rx, logic [11:0] ry);
        logic [31:0] gap;
        gap = it.now_ms - turn_t;
        if (gap < TURN_MIN_GAP_MS) return 0;
        if (!it.reader_menu_active || !it.body_visible) return 0;
        if (!it.turn_accepted) return 0;
        add_ev(next ? EV_PAGE_NEXT : EV_PAGE_PREV, x, y, rx, ry, next ? 4'sd1 : -4'sd1,
               it.now_ms);
        turn_t = it.now_ms;
        return 1;
    endfunction

    task automatic classify(input tgc_in_t it);
        logic [31:0] now, held;
        logic signed [3:0] cnt;
        bit pressed;
        int cx, cy, z, dx, dy, adx, ady, m;
        now = it.now_ms;
        cnt = 4'(it.touch_count);
        pressed = it.touch_pressed && it.touch_count == 1;
        if (!it.touch_enabled)
        begin
            if (finger)
            begin
                finger = 0;
                wfr = 0;
            end
            miss = 0;
            {cand, nxt, fired} = '0;
            def_valid = 0;
            return;
        end
        if (!it.display_pushing && def_valid)
        begin
            def_valid = 0;
            if (post_turn(it, def_next, def_x, def_y, def_rx, def_ry))
            begin
                finger = 0;
                {cand, nxt, fired} = '0;
                if (pressed)
                begin
                    wfr = 1;
                    sup_until = now + RELEASE_HOLDOFF_MS;
                end
                return;
            end
        end
        if (pressed)
        begin
            miss = 0;
            cx = clampc(int'(it.raw_x), cfg.screen_width);
            cy = clampc(int'(it.raw_y), cfg.screen_height);
            if (it.display_pushing || wfr || now < sup_until)
            begin
                late_x = cx; late_y = cy; late_rx = it.raw_x; late_ry = it.raw_y;
                if (it.display_pushing && !def_valid)
                begin
                    z = zone_of(it, cx, cy);
                    if (z >= 0)
                    begin
                        def_valid = 1; def_next = z[0];
                        def_x = cx; def_y = cy; def_rx = it.raw_x; def_ry = it.raw_y;
                    end
                end
                if (it.display_pushing) finger = 0;
                return;
            end
            if (!finger)
            begin
                if (now - rel_t < 32'(cfg.press_debounce_ms)) return;
                finger = 1;
                press_t = now;
                move_t = now;
                press_x = cx; press_y = cy; press_rx = it.raw_x; press_ry = it.raw_y;
                late_x = cx; late_y = cy; late_rx = it.raw_x; late_ry = it.raw_y;
                z = zone_of(it, cx, cy);
                if (z >= 0) {cand, nxt, fired} = {1'b1, z[0], 1'b0};
                else {cand, fired} = '0;
                add_ev(EV_DOWN, cx, cy, it.raw_x, it.raw_y, cnt, now);
                return;
            end
            late_x = cx; late_y = cy; late_rx = it.raw_x; late_ry = it.raw_y;
            if (cand && !fired)
            begin
                dx = cx - press_x; dy = cy - press_y;
                adx = dx < 0 ? -dx : dx; ady = dy < 0 ? -dy : dy;
                m = adx > ady ? adx : ady;
                if (m > int'(cfg.quick_turn_cancel_px))
                    {cand, nxt, fired} = '0;
                else if (now - press_t >= 32'(cfg.quick_turn_stable_ms) &&
                         post_turn(it, nxt, press_x, press_y, press_rx, press_ry))
                begin
                    fired = 1;
                    finger = 0;
                    wfr = 1;
                    sup_until = now + RELEASE_HOLDOFF_MS;
                    return;
                end
            end
            if (now - move_t >= MOVE_INTERVAL_MS)
            begin
                move_t = now;
                add_ev(EV_MOVE, cx, cy, it.raw_x, it.raw_y, cnt, now);
            end
            return;
        end
        if (finger && miss < LIFT_FRAMES)
        begin
            miss++;
            return;
        end
        if (!finger) miss = 0;
        if (wfr && now >= sup_until) wfr = 0;
        if (it.display_pushing || !finger) return;
        finger = 0;
        miss = 0;
        {cand, nxt, fired} = '0;
        rel_t = now;
        dx = late_x - press_x; dy = late_y - press_y;
        adx = dx < 0 ? -dx : dx; ady = dy < 0 ? -dy : dy;
        m = adx > ady ? adx : ady;
        held = now - press_t;
        add_ev(EV_UP, late_x, late_y, late_rx, late_ry, cnt, now);
        if (m <= int'(cfg.tap_slop_px))
            add_ev(held >= 32'(cfg.long_press_ms) ? EV_LONG : EV_TAP, press_x, press_y,
                   late_rx, late_ry, cnt, now);
        else if (adx > ady && adx >= int'(cfg.swipe_px))
            add_ev(dx > 0 ? EV_SW_RIGHT : EV_SW_LEFT, late_x, late_y, late_rx, late_ry, cnt, now);
        else if (ady >= int'(cfg.swipe_px))
            add_ev(dy > 0 ? EV_SW_DOWN : EV_SW_UP, late_x, late_y, late_rx, late_ry, cnt, now);
    endtask

    task automatic predict_events(input tgc_in_t it);
        step_events.delete();
        if (it.mode == MODE_SUP_FOR || it.mode == MODE_SUP_REL)
        begin
            sup_until = it.now_ms + 32'(it.cooldown_ms);
            wfr = it.mode == MODE_SUP_REL;
            finger = 0;
            move_t = 0;
            miss = 0;
            {cand, nxt, fired} = '0;
            def_valid = 0;
        end
        else if (it.mode == MODE_SAMPLE)
            classify(it);
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last_of_run = 1;
        foreach (step_events[i]) pending_events.push_back(step_events[i]);
    endtask

    task automatic send(input tgc_in_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_events(it);
        sent++;
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_SCREEN_W:   cfg.screen_width = v[10:0];
            REG_SCREEN_H:   cfg.screen_height = v[10:0];
            REG_TAP_SLOP:   cfg.tap_slop_px = v[9:0];
            REG_LONG_PRESS: cfg.long_press_ms = v[15:0];
            REG_SWIPE:      cfg.swipe_px = v[9:0];
            REG_PRESS_DB:   cfg.press_debounce_ms = v[15:0];
            REG_QT_STABLE:  cfg.quick_turn_stable_ms = v[15:0];
            default:        cfg.quick_turn_cancel_px = v[9:0];
        endcase
    endtask

    task automatic write_all(input tgc_cfg_t c);
        apb_write(REG_SCREEN_W, 32'(c.screen_width));
        apb_write(REG_SCREEN_H, 32'(c.screen_height));
        apb_write(REG_TAP_SLOP, 32'(c.tap_slop_px));
        apb_write(REG_LONG_PRESS, 32'(c.long_press_ms));
        apb_write(REG_SWIPE, 32'(c.swipe_px));
        apb_write(REG_PRESS_DB, 32'(c.press_debounce_ms));
        apb_write(REG_QT_STABLE, 32'(c.quick_turn_stable_ms));
        apb_write(REG_QT_CANCEL, 32'(c.quick_turn_cancel_px));
    endtask

    function automatic tgc_in_t mk(logic [1:0] mode, logic [31:0] now, bit en, bit pr,
                                   int cnt, int x, int y, bit push, bit rd, bit body,
                                   bit acc, int cool);
        tgc_in_t it;
        it.mode = mode; it.now_ms = now; it.touch_enabled = en; it.touch_pressed = pr;
        it.touch_count = 3'(cnt); it.raw_x = 12'(x); it.raw_y = 12'(y);
        it.display_pushing = push; it.reader_menu_active = rd; it.body_visible = body;
        it.turn_accepted = acc; it.cooldown_ms = 16'(cool);
        return it;
    endfunction

    function automatic void add_row(tgc_in_t it, bit known, int n, logic [3:0] kind);
        row_t r;
        r.item = it; r.known = known; r.n = n; r.kind = kind;
        stim_rows.push_back(r);
    endfunction

    function automatic int pick_coord(int base, int drift);
        int v;
        v = base + $urandom_range(0, 2 * drift) - drift;
        if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 4095) - 2048;
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return v;
    endfunction

    task automatic noise_item();
        tgc_in_t it;
        it = tgc_in_t'($bits(tgc_in_t)'({$urandom, $urandom, $urandom}));
        it.now_ms = ms_now;
        if ($urandom_range(0, 3) != 0) it.cooldown_ms = 16'($urandom_range(0, 200));
        send(it);
    endtask

    task automatic gesture();
        tgc_in_t it;
        int k, nrel, i, w, bx, by, drift, r;
        bit rd, bd, acc, push;
        w = cfg.screen_width == 0 ? 1 : cfg.screen_width;
        rd = $urandom_range(0, 4) != 0;
        bd = $urandom_range(0, 4) != 0;
        acc = $urandom_range(0, 4) != 0;
        push = $urandom_range(0, 5) == 0;
        r = $urandom_range(0, 3);
        bx = r == 0 ? $urandom_range(0, w / 3) : r == 1 ? $urandom_range(w * 2 / 3, w) :
             $urandom_range(0, w);
        by = $urandom_range(0, cfg.screen_height);
        r = $urandom_range(0, 2);
        drift = r == 0 ? 2 : r == 1 ? 30 : 150;
        if ($urandom_range(0, 39) == 0) ms_now = $urandom;
        if ($urandom_range(0, 5) == 0) noise_item();
        ms_now += $urandom_range(0, 300);
        k = $urandom_range(1, 8);
        for (i = 0; i < k; i++)
        begin
            it = mk(MODE_SAMPLE, ms_now, 1, 1, 1, pick_coord(bx, drift),
                    pick_coord(by, drift), push && i < 2, rd, bd, acc, 0);
            if ($urandom_range(0, 19) == 0) it.touch_count = 3'($urandom_range(0, 7));
            send(it);
            ms_now += $urandom_range(0, 9) == 0 ? $urandom_range(200, 2000) :
                      $urandom_range(1, 150);
        end
        nrel = $urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 5);
        for (i = 0; i < nrel; i++)
        begin
            it = mk(MODE_SAMPLE, ms_now, 1, $urandom_range(0, 1) && i > 0, 0,
                    pick_coord(bx, 100), pick_coord(by, 100),
                    $urandom_range(0, 9) == 0, rd, bd, acc, 0);
            it.touch_count = 3'($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 0);
            send(it);
            ms_now += $urandom_range(1, 40);
        end
    endtask

    // result side: random stall before each transfer, check against oldest prediction
    initial
    begin
        int n;
        tgc_out_t e;
        @(posedge rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 18);
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_events.size() == 0)
                report($sformatf("unexpected event kind %0d", out_item.event_kind));
            else
            begin
                e = pending_events.pop_front();
                checked++;
                if (out_item.event_kind !== e.event_kind)
                    report($sformatf("kind %0d exp %0d", out_item.event_kind, e.event_kind));
                if (out_item.point_x !== e.point_x)
                    report($sformatf("point_x %0d exp %0d", out_item.point_x, e.point_x));
                if (out_item.point_y !== e.point_y)
                    report($sformatf("point_y %0d exp %0d", out_item.point_y, e.point_y));
                if (out_item.raw_point_x !== e.raw_point_x)
                    report($sformatf("raw_x %0d exp %0d", out_item.raw_point_x, e.raw_point_x));
                if (out_item.raw_point_y !== e.raw_point_y)
                    report($sformatf("raw_y %0d exp %0d", out_item.raw_point_y, e.raw_point_y));
                if (out_item.event_value !== e.event_value)
                    report($sformatf("value %0d exp %0d", out_item.event_value, e.event_value));
                if (out_item.event_time !== e.event_time)
                    report($sformatf("time %0h exp %0h", out_item.event_time, e.event_time));
                if (out_item.last_of_run !== e.last_of_run)
                    report($sformatf("last %0b exp %0b", out_item.last_of_run, e.last_of_run));
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        tgc_cfg_t c;
        int p, k;
        cfg = '{540, 960, 50, 600, 80, 18, 35, 58};
        {finger, wfr, miss, cand, nxt, fired, def_valid} = '0;
        {sup_until, rel_t, press_t, move_t, turn_t} = '0;
        {press_x, press_y, late_x, late_y} = '0;
        {press_rx, press_ry, late_rx, late_ry} = '0;
        ms_now = 32'd10000;

        add_row(mk(MODE_SAMPLE, 1000, 1, 1, 1, 100, 500, 0, 0, 0, 0, 0), 1, 1, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 1150, 1, 1, 1, 120, 510, 0, 0, 0, 0, 0), 1, 1, EV_MOVE);
        add_row(mk(MODE_SAMPLE, 1160, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 1170, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 1180, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 1190, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 2, EV_UP);
        add_row(mk(MODE_SAMPLE, 2000, 1, 1, 1, -2048, -2048, 0, 0, 0, 0, 0), 1, 1, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 2010, 1, 1, 1, 2047, 2047, 0, 0, 0, 0, 0), 1, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 2020, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 2030, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 2040, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 2050, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 2, EV_UP);
        add_row(mk(2'd3, 2060, 1, 1, 1, 10, 10, 1, 1, 1, 1, 7), 1, 0, EV_DOWN);
        add_row(mk(MODE_SUP_FOR, 3000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535), 1, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 3010, 1, 1, 1, 200, 300, 0, 0, 0, 0, 0), 1, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 3020, 0, 1, 1, 200, 300, 0, 0, 0, 0, 0), 1, 0, EV_DOWN);
        add_row(mk(MODE_SUP_REL, 4000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 5000, 1, 1, 1, 500, 500, 0, 1, 1, 1, 0), 1, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 5010, 1, 0, 0, 0, 0, 0, 1, 1, 1, 0), 1, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 5100, 1, 1, 1, 500, 500, 0, 1, 1, 1, 0), 1, 1, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 5200, 1, 1, 1, 505, 500, 0, 1, 1, 1, 0), 1, 1, EV_PAGE_NEXT);
        add_row(mk(MODE_SAMPLE, 5300, 1, 0, 0, 0, 0, 0, 1, 1, 1, 0), 0, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 5400, 1, 1, 1, 50, 500, 1, 1, 1, 1, 0), 1, 0, EV_DOWN);
        add_row(mk(MODE_SAMPLE, 5500, 1, 1, 1, 50, 500, 0, 1, 1, 1, 0), 1, 1, EV_PAGE_PREV);
        add_row(mk(MODE_SAMPLE, 5600, 1, 1, 5, 60, 500, 0, 1, 1, 1, 0), 1, 0, EV_DOWN);

        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                in_valid <= 0;
                wait (pending_events.size() == 0);
                repeat (6) @(posedge clk);
                case (p)
                    1: c = '{1, 1, 0, 0, 0, 0, 0, 0};
                    2: c = '{2047, 2047, 1023, 65535, 1023, 65535, 65535, 1023};
                    default: c = '{$urandom_range(200, 2047), $urandom_range(200, 2047),
                                   $urandom_range(0, 100), $urandom_range(100, 1500),
                                   $urandom_range(20, 300), $urandom_range(0, 40),
                                   $urandom_range(0, 200), $urandom_range(10, 150)};
                endcase
                if (p == 2) c.press_debounce_ms = 16'($urandom_range(0, 40));
                write_all(c);
            end
            else
            begin
                foreach (stim_rows[i])
                begin
                    send(stim_rows[i].item);
                    if (stim_rows[i].known && (step_events.size() != stim_rows[i].n ||
                        (stim_rows[i].n > 0 && step_events[0].event_kind !== stim_rows[i].kind)))
                        report($sformatf("directed row %0d predicted %0d events", i,
                                         step_events.size()));
                end
            end
            k = 0;
            while (sent < (p + 1) * 175)
            begin
                if (k % 40 == 0) calm = $urandom_range(0, 3) == 0;
                gesture();
                k++;
            end
        end
        in_valid <= 0;
        wait (pending_events.size() == 0);
        repeat (10) @(posedge clk);
        $display("Covered %0d input transfers and %0d checked events over 6 register settings.",
                 sent, checked);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
